// File: rtl/ctlex_pkg.sv
package ctlex_pkg;

    // controller to datapath
    typedef struct packed {
        logic accept;      // input word taken this cycle
        logic flush_emit;  // load the next character of the open token
        logic tail_run;    // handle the held character after any flush
    } ctlex_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic absorb;      // incoming character extends the open run
        logic has_open;    // a number, identifier or sign is open
        logic flush_last;  // current flush character is the token's last
        logic is_incdec;   // open sign is doubled by the held character
        logic tail_emit;   // held character produces a token
        logic slot_free;   // output register can take a word
    } ctlex_status_t;

endpackage

// File: rtl/ctlex_ctrl.sv
module ctlex_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  ctlex_pkg::ctlex_status_t status,
    output ctlex_pkg::ctlex_cmd_t    cmd
);
    import ctlex_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_TAIL
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_tvalid;
                if (s_tvalid && !status.absorb) begin
                    state_next = status.has_open ? ST_FLUSH : ST_TAIL;
                end
            end
            ST_FLUSH: begin
                cmd.flush_emit = status.slot_free;
                if (status.slot_free && status.flush_last) begin
                    // a doubled sign consumes the held character
                    state_next = status.is_incdec ? ST_IDLE : ST_TAIL;
                end
            end
            ST_TAIL: begin
                if (!status.tail_emit || status.slot_free) begin
                    cmd.tail_run = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/ctlex_datapath.sv
module ctlex_datapath #(
    parameter int MAX_LEXEME = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [7:0]              s_tdata,
    input  logic [0:0]              s_tuser,
    input  ctlex_pkg::ctlex_cmd_t    cmd,
    output ctlex_pkg::ctlex_status_t status,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [23:0]             m_tdata,
    output logic [3:0]              m_tuser,
    output logic                    m_tlast
);
    import ctlex_pkg::*;

    localparam int LexCap   = (MAX_LEXEME - 1 < 31) ? MAX_LEXEME - 1 : 31;
    localparam int LexDepth = (LexCap < 2) ? 2 : LexCap;
    localparam int IdxW     = $clog2(LexDepth);

    localparam logic [3:0] K_UNKNOWN = 4'd0;
    localparam logic [3:0] K_END     = 4'd1;
    localparam logic [3:0] K_EOF     = 4'd2;
    localparam logic [3:0] K_INT     = 4'd3;
    localparam logic [3:0] K_ID      = 4'd4;
    localparam logic [3:0] K_ADDSUB  = 4'd5;
    localparam logic [3:0] K_INCDEC  = 4'd6;
    localparam logic [3:0] K_MULDIV  = 4'd7;
    localparam logic [3:0] K_ASSIGN  = 4'd8;
    localparam logic [3:0] K_LPAREN  = 4'd9;
    localparam logic [3:0] K_RPAREN  = 4'd10;
    localparam logic [3:0] K_AND     = 4'd11;
    localparam logic [3:0] K_OR      = 4'd12;
    localparam logic [3:0] K_XOR     = 4'd13;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_CARET  = 8'h5E;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_NAME,
        MODE_SIGN
    } mode_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    mode_t      mode_reg;
    logic [4:0] count_reg;
    logic [7:0] store_reg [LexDepth];
    logic [7:0] sign_reg;
    logic [7:0] char_reg;
    logic       eof_reg;
    logic [4:0] flush_idx_reg;

    logic       out_valid_reg;
    logic [3:0] out_kind_reg;
    logic [7:0] out_char_reg;
    logic [4:0] out_pos_reg;
    logic [4:0] out_len_reg;
    logic       out_last_reg;

    logic       in_eof;
    logic       fits;
    logic [4:0] flush_len;
    logic [3:0] flush_kind;
    logic [7:0] flush_char;

    logic       tail_emit;
    logic       tail_text;
    logic [3:0] tail_kind;
    logic       tail_start;
    mode_t      tail_mode;

    logic       load_flush;
    logic       load_tail;

    assign in_eof = s_tuser[0];

    always_comb begin
        if (mode_reg == MODE_NUM) begin
            fits = is_digit(s_tdata);
        end else begin
            fits = is_digit(s_tdata) || is_letter(s_tdata) || (s_tdata == CH_UNDER);
        end
    end

    assign status.absorb = ((mode_reg == MODE_NUM) || (mode_reg == MODE_NAME))
                         && !in_eof && fits && (count_reg < 5'(LexCap));
    assign status.has_open  = (mode_reg != MODE_IDLE);
    assign status.is_incdec = (mode_reg == MODE_SIGN) && !eof_reg && (char_reg == sign_reg);

    always_comb begin
        flush_len  = count_reg;
        flush_kind = K_UNKNOWN;
        flush_char = store_reg[flush_idx_reg[IdxW-1:0]];
        case (mode_reg)
            MODE_NUM:  flush_kind = K_INT;
            MODE_NAME: flush_kind = K_ID;
            MODE_SIGN: begin
                flush_kind = status.is_incdec ? K_INCDEC : K_ADDSUB;
                flush_len  = status.is_incdec ? 5'd2 : 5'd1;
                flush_char = sign_reg;
            end
            default: flush_kind = K_UNKNOWN;
        endcase
    end

    assign status.flush_last = (flush_idx_reg == flush_len - 5'd1);

    // what the held character does once any open token is gone
    always_comb begin
        tail_emit  = 1'b0;
        tail_text  = 1'b0;
        tail_kind  = K_UNKNOWN;
        tail_start = 1'b0;
        tail_mode  = MODE_IDLE;
        if (eof_reg) begin
            tail_emit = 1'b1;
            tail_kind = K_EOF;
        end else if (char_reg == CH_SPACE || char_reg == CH_TAB) begin
            tail_emit = 1'b0;
        end else if (is_digit(char_reg)) begin
            tail_start = 1'b1;
            tail_mode  = MODE_NUM;
        end else if (is_letter(char_reg) || char_reg == CH_UNDER) begin
            tail_start = 1'b1;
            tail_mode  = MODE_NAME;
        end else if (char_reg == CH_PLUS || char_reg == CH_MINUS) begin
            tail_mode = MODE_SIGN;
        end else begin
            tail_emit = 1'b1;
            tail_text = 1'b1;
            case (char_reg)
                CH_STAR, CH_SLASH: tail_kind = K_MULDIV;
                CH_EQ:             tail_kind = K_ASSIGN;
                CH_LPAR:           tail_kind = K_LPAREN;
                CH_RPAR:           tail_kind = K_RPAREN;
                CH_AMP:            tail_kind = K_AND;
                CH_PIPE:           tail_kind = K_OR;
                CH_CARET:          tail_kind = K_XOR;
                CH_NL: begin
                    tail_kind = K_END;
                    tail_text = 1'b0;
                end
                default: begin
                    tail_kind = K_UNKNOWN;
                    tail_text = 1'b0;
                end
            endcase
        end
    end

    assign status.tail_emit = tail_emit;
    assign status.slot_free = !out_valid_reg || m_tready;

    assign load_flush = cmd.flush_emit;
    assign load_tail  = cmd.tail_run && tail_emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            count_reg     <= '0;
            flush_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept && status.absorb) begin
                count_reg <= count_reg + 5'd1;
            end
            if (cmd.flush_emit) begin
                flush_idx_reg <= status.flush_last ? 5'd0 : flush_idx_reg + 5'd1;
                if (status.flush_last) begin
                    mode_reg <= MODE_IDLE;
                end
            end
            if (cmd.tail_run) begin
                mode_reg <= tail_mode;
                if (tail_start) begin
                    count_reg <= 5'd1;
                end
            end
            if (load_flush || load_tail) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && status.absorb) begin
            store_reg[count_reg[IdxW-1:0]] <= s_tdata;
        end
        if (cmd.tail_run && tail_start) begin
            store_reg[0] <= char_reg;
        end
        if (cmd.tail_run && tail_mode == MODE_SIGN) begin
            sign_reg <= char_reg;
        end
        if (cmd.accept && !status.absorb) begin
            char_reg <= s_tdata;
            eof_reg  <= in_eof;
        end
        if (load_flush) begin
            out_kind_reg <= flush_kind;
            out_char_reg <= flush_char;
            out_pos_reg  <= flush_idx_reg;
            out_len_reg  <= flush_len;
            out_last_reg <= status.flush_last;
        end else if (load_tail) begin
            out_kind_reg <= tail_kind;
            out_char_reg <= tail_text ? char_reg : 8'd0;
            out_pos_reg  <= 5'd0;
            out_len_reg  <= tail_text ? 5'd1 : 5'd0;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_len_reg, out_pos_reg, out_char_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/calculator_token_lexer.sv
// channel  direction  ports                          word
// s_       in         tvalid tready tdata tuser      one character or end-of-file mark
// m_       out        tvalid tready tdata tuser tlast one lexeme character of a token
//
// a character that extends a number or identifier is taken in the idle state, which it never leaves
// a character with nothing open is handled in the tail state, which waits for a free output slot if it emits
// a character that closes a token first goes through the flush state, one emitted word per
// lexeme character, then the tail state handles the closing character, except a doubled sign
// the output register holds one word; stalls on m_ stop the flush and s_tready stays low
// reset clears the scan mode and lexeme count; the lexeme store needs no clearing
module calculator_token_lexer #(
    parameter int MAX_LEXEME = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_in
    input  logic [0:0]  s_tuser,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // lexeme_char, char_position, lexeme_length
    output logic [3:0]  m_tuser,   // token_kind
    output logic        m_tlast
);
    import ctlex_pkg::*;

    ctlex_cmd_t    cmd;
    ctlex_status_t status;

    ctlex_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ctlex_datapath #(
        .MAX_LEXEME (MAX_LEXEME)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
